/* rtl/sfsh_pkg.sv */
// Shared types, constants and mixing functions of the S-box Feistel stream hash.
// No dependencies; used by the top level, front end, queue, lane and back end through scoped names.
package sfsh_pkg;

    localparam logic [63:0] SEED_RESET = 64'h517CC1B727220A95;
    localparam logic [63:0] GOLDEN     = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_A      = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_B      = 64'h94D049BB133111EB;
    localparam logic [63:0] ROUND_MUL  = 64'h517CC1B727220A95;
    localparam logic [63:0] FINAL_KEY_ROUND = 64'd99;
    localparam int unsigned ROUNDS = 8;

    // configuration register indexes
    localparam logic CFG_SEED = 1'b0;
    localparam logic CFG_WIDE = 1'b1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // one unit of work for the back end
    typedef struct packed {
        logic        is_empty;
        logic        is_final;
        logic        chain_start;
        logic        wide;
        logic [63:0] seed;
        logic [63:0] start_seed;
        logic [63:0] words;
        logic [63:0] index;
        logic [63:0] len;
    } job_t;

    typedef struct packed {
        logic start;
        logic ack;
    } lane_ctl_t;

    typedef struct packed {
        logic        idle;
        logic        res_valid;
        logic [63:0] res;
    } lane_stat_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } hash_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned n);
        return (x << n) | (x >> (64 - n));
    endfunction

    function automatic logic [63:0] sub_word(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i*8 +: 8] = SBOX[v[i*8 +: 8]];
        end
        return r;
    endfunction

    function automatic hash_t emit(input logic [63:0] hi, input logic [63:0] lo,
                                   input logic wide);
        hash_t h;
        if (wide)
        begin
            h.hi = hi ^ rotl(lo, 23);
            h.lo = lo ^ rotl(h.hi, 37);
        end
        else
        begin
            h.hi = hi;
            h.lo = '0;
        end
        return h;
    endfunction

endpackage

/* rtl/sfsh_if.sv */
// Handshake channels of the stream hash: message bytes, hash results, register writes.
// Depends on nothing; each carries valid, ready and its payload.
interface sfsh_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_message;
    modport source (output valid, data_byte, last_byte, empty_message, input ready);
    modport sink (input valid, data_byte, last_byte, empty_message, output ready);
endinterface

interface sfsh_hash_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_high;
    logic [63:0] hash_low;
    modport source (output valid, hash_high, hash_low, input ready);
    modport sink (input valid, hash_high, hash_low, output ready);
endinterface

interface sfsh_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/sbox_feistel_stream_hash.sv */
// Top level of the S-box Feistel stream hash: configuration registers, front end,
// job queue and back end. Depends on sfsh_pkg, sfsh_if, sfsh_front, sfsh_fifo, sfsh_back.
//
// Usage:
//   msg  : one message byte per transaction, last_byte on the final byte; a transaction
//          with empty_message set asks for the hash of a zero-length message.
//   hash : one transaction per finished message (hash_high, hash_low).
//   cfg  : register writes, index 0 = seed, index 1 = wide_mode; always ready.
//          Write only while no message is in flight.
// The front end takes one byte per cycle while the four-entry job queue has room.
// Each 64-byte block (or final partial block) passes through the back end in steps: a load,
// then eight Feistel rounds of key states KA, KB, KC and round state RD (a split 64-bit
// multiplier is the limit), then a chain step. A final block adds length and key mixing
// (FL, FM, FA, FB, FC). Long messages stream at one byte per cycle while the queue has
// room; short messages are bounded by the back end.
// An empty message goes straight to the result register.
// Reset clears the message state and loads the default seed and 64-bit mode.
// A stalled hash receiver holds the result register; the queue then fills and
// msg.ready drops.
module sbox_feistel_stream_hash #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    sfsh_cfg_if.sink    cfg,
    sfsh_msg_if.sink    msg,
    sfsh_hash_if.source hash
);
    logic [63:0]    seed_reg, seed_next;
    logic           wide_reg, wide_next;
    logic           push, pop, full, empty;
    sfsh_pkg::job_t job_in, job_out;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        seed_next = seed_reg;
        wide_next = wide_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                sfsh_pkg::CFG_SEED: seed_next = cfg.data;
                sfsh_pkg::CFG_WIDE: wide_next = cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= sfsh_pkg::SEED_RESET;
            wide_reg <= 1'b0;
        end
        else
        begin
            seed_reg <= seed_next;
            wide_reg <= wide_next;
        end
    end

    sfsh_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk  (clk),
        .rst_n(rst_n),
        .msg  (msg),
        .seed (seed_reg),
        .wide (wide_reg),
        .full (full),
        .push (push),
        .job  (job_in)
    );

    sfsh_fifo u_fifo (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .din  (job_in),
        .pop  (pop),
        .dout (job_out),
        .full (full),
        .empty(empty)
    );

    sfsh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job_out),
        .job_valid(!empty),
        .pop      (pop),
        .hash     (hash)
    );

endmodule

/* rtl/sfsh_front.sv */
// Front end: takes message bytes, assembles words and blocks, issues jobs.
// Depends on sfsh_pkg and the message channel interface.
module sfsh_front #(
    parameter int LENGTH_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    sfsh_msg_if.sink         msg,
    input  logic [63:0]      seed,
    input  logic             wide,
    input  logic             full,
    output logic             push,
    output sfsh_pkg::job_t   job
);
    localparam int COUNT_BITS = LENGTH_BITS - 6;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic [LENGTH_BITS-1:0] len_reg, len_next, len_inc;
    logic [COUNT_BITS-1:0]  bc_reg, bc_next;
    logic [5:0]             bib_reg, bib_next;
    logic [63:0]            wa_reg, wa_next;
    logic [63:0]            bwx_reg, bwx_next;
    logic [63:0]            ss_reg, ss_next;
    logic                   pend_reg, pend_next;

    logic [6:0]  n;
    logic [2:0]  tail;
    logic [63:0] wa, bwx_upd, tail_word;
    logic        word_full, finish, len_is0, accept;

    assign msg.ready = !full;
    assign accept    = msg.valid && msg.ready;

    always_comb
    begin
        n         = {1'b0, bib_reg} + 7'd1;
        tail      = n[2:0];
        wa        = {wa_reg[55:0], msg.data_byte};
        word_full = (tail == 3'd0);
        bwx_upd   = word_full ? (bwx_reg ^ wa) : bwx_reg;
        // left-align a short tail word
        tail_word = wa << {3'(4'd8 - {1'b0, tail}), 3'b000};
        finish    = (n == 7'd64) || msg.last_byte;
        len_is0   = (len_reg == '0);
        len_inc   = (len_reg == LEN_MAX) ? len_reg : len_reg + 1'b1;

        job.is_empty    = msg.empty_message;
        job.is_final    = msg.last_byte;
        job.chain_start = len_is0 || pend_reg;
        job.wide        = wide;
        job.seed        = seed;
        job.start_seed  = len_is0 ? seed : ss_reg;
        job.words       = word_full ? bwx_upd : (bwx_upd ^ tail_word);
        job.index       = 64'(bc_reg);
        job.len         = 64'(len_inc);

        len_next  = len_reg;
        bc_next   = bc_reg;
        bib_next  = bib_reg;
        wa_next   = wa_reg;
        bwx_next  = bwx_reg;
        ss_next   = ss_reg;
        pend_next = pend_reg;
        push      = 1'b0;

        if (accept)
        begin
            if (msg.empty_message)
            begin
                // drop any partial message
                push      = 1'b1;
                len_next  = '0;
                bc_next   = '0;
                bib_next  = '0;
                wa_next   = '0;
                bwx_next  = '0;
                pend_next = 1'b0;
            end
            else
            begin
                if (len_is0)
                begin
                    ss_next   = seed;
                    pend_next = 1'b1;
                end
                len_next = len_inc;
                if (finish)
                begin
                    push      = 1'b1;
                    pend_next = 1'b0;
                    bc_next   = bc_reg + 1'b1;
                    bib_next  = '0;
                    wa_next   = '0;
                    bwx_next  = '0;
                end
                else
                begin
                    bib_next = n[5:0];
                    bwx_next = bwx_upd;
                    wa_next  = word_full ? '0 : wa;
                end
                if (msg.last_byte)
                begin
                    len_next = '0;
                    bc_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            bc_reg   <= '0;
            bib_reg  <= '0;
            wa_reg   <= '0;
            bwx_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            bc_reg   <= bc_next;
            bib_reg  <= bib_next;
            wa_reg   <= wa_next;
            bwx_reg  <= bwx_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ss_reg <= ss_next;
    end

endmodule

/* rtl/sfsh_fifo.sv */
// Short job queue between front and back end.
// Depends on sfsh_pkg for the job type.
module sfsh_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfsh_pkg::job_t din,
    input  logic           pop,
    output sfsh_pkg::job_t dout,
    output logic           full,
    output logic           empty
);
    localparam int DEPTH = 4;
    localparam int AW = $clog2(DEPTH);

    sfsh_pkg::job_t  mem [DEPTH];
    logic [AW-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]     cnt_reg, cnt_next;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= din;
        end
    end

endmodule

/* rtl/sfsh_lane.sv */
// One hash lane: 8 Feistel rounds per block, chaining and final mixing.
// Depends on sfsh_pkg; a 64-bit product is split into three 32x32 partial products.
module sfsh_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  sfsh_pkg::lane_ctl_t ctl,
    input  sfsh_pkg::job_t      job,
    output sfsh_pkg::lane_stat_t stat
);
    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_KA   = 12'b000000000010,
        S_KB   = 12'b000000000100,
        S_KC   = 12'b000000001000,
        S_RD   = 12'b000000010000,
        S_CH   = 12'b000000100000,
        S_FL   = 12'b000001000000,
        S_FM   = 12'b000010000000,
        S_FA   = 12'b000100000000,
        S_FB   = 12'b001000000000,
        S_FC   = 12'b010000000000,
        S_DN   = 12'b100000000000
    } lane_state_t;

    lane_state_t st_reg, st_next;
    logic [63:0] l_reg, l_next, r_reg, r_next, chain_reg, chain_next;
    logic [63:0] gm_reg, gm_next, s_reg, s_next, len_reg, len_next;
    logic [63:0] fc_reg, fc_next, res_reg, res_next;
    logic [2:0]  rnd_reg, rnd_next;
    logic        fin_reg, fin_next;
    logic [63:0] pp0_reg, pp0_next;
    logic [31:0] pp1_reg, pp1_next, pp2_reg, pp2_next;
    logic [63:0] mul_a, mul_b, prod, h, ka, key;

    assign prod = pp0_reg + {pp1_reg + pp2_reg, 32'b0};

    // low 64 bits of the product from three partial products
    assign pp0_next = 64'(mul_a[31:0]) * 64'(mul_b[31:0]);
    assign pp1_next = mul_a[63:32] * mul_b[31:0];
    assign pp2_next = mul_a[31:0] * mul_b[63:32];

    assign stat.idle      = (st_reg == S_IDLE);
    assign stat.res_valid = (st_reg == S_DN);
    assign stat.res       = res_reg;

    always_comb
    begin
        st_next    = st_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        chain_next = chain_reg;
        gm_next    = gm_reg;
        s_next     = s_reg;
        len_next   = len_reg;
        fc_next    = fc_reg;
        res_next   = res_reg;
        rnd_next   = rnd_reg;
        fin_next   = fin_reg;
        mul_a      = '0;
        mul_b      = '0;
        h          = job.seed ^ job.index ^ job.words;
        ka         = '0;
        key        = prod ^ (prod >> 31);

        case (st_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    chain_next = job.chain_start ? job.start_seed : chain_reg;
                    l_next     = h;
                    r_next     = job.seed ^ sfsh_pkg::rotl(h, 17);
                    gm_next    = '0;
                    rnd_next   = '0;
                    s_next     = job.seed;
                    len_next   = job.len;
                    fin_next   = job.is_final;
                    st_next    = S_KA;
                end
            end
            S_KA:
            begin
                ka      = s_reg ^ gm_reg;
                mul_a   = ka ^ (ka >> 30);
                mul_b   = sfsh_pkg::MIX_A;
                st_next = S_KB;
            end
            S_KB, S_FB:
            begin
                mul_a   = prod ^ (prod >> 27);
                mul_b   = sfsh_pkg::MIX_B;
                st_next = (st_reg == S_KB) ? S_KC : S_FC;
            end
            S_KC:
            begin
                mul_a   = sfsh_pkg::rotl(sfsh_pkg::sub_word(l_reg ^ key), 13);
                mul_b   = sfsh_pkg::ROUND_MUL;
                st_next = S_RD;
            end
            S_RD:
            begin
                l_next   = sfsh_pkg::rotl(prod, 7) ^ r_reg;
                r_next   = l_reg;
                gm_next  = gm_reg + sfsh_pkg::GOLDEN;
                rnd_next = rnd_reg + 1'b1;
                st_next  = (rnd_reg == 3'(sfsh_pkg::ROUNDS - 1)) ? S_CH : S_KA;
            end
            S_CH:
            begin
                chain_next = sfsh_pkg::rotl(sfsh_pkg::sub_word(chain_reg ^ l_reg ^ r_reg), 17);
                st_next    = fin_reg ? S_FL : S_IDLE;
            end
            S_FL:
            begin
                mul_a   = len_reg;
                mul_b   = sfsh_pkg::GOLDEN;
                st_next = S_FM;
            end
            S_FM:
            begin
                fc_next = sfsh_pkg::sub_word(chain_reg ^ prod);
                mul_a   = sfsh_pkg::FINAL_KEY_ROUND;
                mul_b   = sfsh_pkg::GOLDEN;
                st_next = S_FA;
            end
            S_FA:
            begin
                ka      = s_reg ^ prod;
                mul_a   = ka ^ (ka >> 30);
                mul_b   = sfsh_pkg::MIX_A;
                st_next = S_FB;
            end
            S_FC:
            begin
                res_next = fc_reg ^ key;
                st_next  = S_DN;
            end
            S_DN:
            begin
                // hold the result until the back end takes it
                if (ctl.ack)
                begin
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            rnd_reg <= '0;
            fin_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            rnd_reg <= rnd_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg     <= l_next;
        r_reg     <= r_next;
        chain_reg <= chain_next;
        gm_reg    <= gm_next;
        s_reg     <= s_next;
        len_reg   <= len_next;
        fc_reg    <= fc_next;
        res_reg   <= res_next;
        pp0_reg   <= pp0_next;
        pp1_reg   <= pp1_next;
        pp2_reg   <= pp2_next;
    end

endmodule

/* rtl/sfsh_back.sv */
// Back end: runs queued jobs on the main and inverted lanes, holds the result register.
// Depends on sfsh_pkg, sfsh_lane and the hash channel interface.
module sfsh_back (
    input  logic           clk,
    input  logic           rst_n,
    input  sfsh_pkg::job_t job,
    input  logic           job_valid,
    output logic           pop,
    sfsh_hash_if.source    hash
);
    sfsh_pkg::job_t       job_inv;
    sfsh_pkg::lane_ctl_t  ctl;
    sfsh_pkg::lane_stat_t st_main, st_inv;
    sfsh_pkg::hash_t      out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 wide_reg, wide_next;
    logic                 slot_free, load_res, load_empty;

    always_comb
    begin
        job_inv            = job;
        job_inv.seed       = ~job.seed;
        job_inv.start_seed = ~job.start_seed;
    end

    assign slot_free  = !out_valid_reg || hash.ready;
    assign load_res   = st_main.res_valid && slot_free;
    assign pop        = job_valid && st_main.idle && (!job.is_empty || slot_free);
    assign load_empty = pop && job.is_empty;
    assign ctl.start  = pop && !job.is_empty;
    assign ctl.ack    = load_res;

    sfsh_lane u_lane_main (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .job  (job),
        .stat (st_main)
    );

    sfsh_lane u_lane_inv (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .job  (job_inv),
        .stat (st_inv)
    );

    always_comb
    begin
        wide_next      = ctl.start ? job.wide : wide_reg;
        out_next       = out_reg;
        out_valid_next = hash.ready ? 1'b0 : out_valid_reg;
        if (load_res)
        begin
            out_next       = sfsh_pkg::emit(st_main.res, st_inv.res, wide_reg);
            out_valid_next = 1'b1;
        end
        else if (load_empty)
        begin
            out_next       = sfsh_pkg::emit(job.seed, ~job.seed, job.wide);
            out_valid_next = 1'b1;
        end
    end

    assign hash.valid     = out_valid_reg;
    assign hash.hash_high = out_reg.hi;
    assign hash.hash_low  = out_reg.lo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        wide_reg <= wide_next;
    end

    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (st_main.idle == st_inv.idle) && (st_main.res_valid == st_inv.res_valid))
        else $error("lanes out of step");

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> job_valid)
        else $error("job taken from an empty queue");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hash.ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting hash overwritten");

    a_res_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        st_main.res_valid |-> !st_main.idle && !pop)
        else $error("new job started over a pending result");

endmodule
